// ===== hw/rtl/curve_subdivision_step_assert.svh =====
// Assertion macros used by the curve subdivision RTL.
`ifndef CURVE_SUBDIVISION_STEP_ASSERT_SVH
`define CURVE_SUBDIVISION_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check prop at every rising clock edge outside reset.
`define CSUB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond never holds outside reset.
`define CSUB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CSUB_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSUB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/csub_pkg.sv =====
// Shared types and constants of the curve subdivision block.
package csub_pkg;

    localparam int DEF_COORD_WIDTH = 24;
    localparam int MAX_RES         = 4;
    localparam int RES_IDX_W       = $clog2(MAX_RES);
    localparam int QDEPTH          = 2;

    // Term slots carried with every job
    localparam int T_A     = 0;
    localparam int T_H1    = 1;
    localparam int T_H0    = 2;
    localparam int T_P     = 3;
    localparam int T_G     = 4;
    localparam int NTERM   = 5;
    localparam int GUARD_W = 2;

    typedef enum logic [2:0] {
        K_PT,
        K_MID,
        K_VTX,
        K_FR1,
        K_HIST,
        K_FR2
    } t_kind;

    typedef struct packed {
        t_kind [MAX_RES-1:0]  kinds;
        logic [RES_IDX_W-1:0] last_idx;
        logic                 last;
    } t_job_ctrl;

endpackage

// ===== hw/rtl/csub_point_if.sv =====
// Valid/ready channel carrying one curve point.
interface csub_point_if #(
    parameter int COORD_WIDTH = csub_pkg::DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          last;

    modport source (output valid, x, y, last, input ready);
    modport sink   (input valid, x, y, last, output ready);
endinterface

// ===== hw/rtl/curve_subdivision_step.sv =====
// Top level of one curve subdivision level: front end, job queue and back end.
//
//  channel  | dir | handshake       | payload
//  i_pt     | in  | valid / ready   | x, y (signed Q16.8), last
//  o_pt     | out | valid / ready   | x, y (signed Q16.8, saturated), last
//  cfg      | in  | i_cfg_we        | i_cfg_wdata = scheme mode
//
//  A point is accepted while the job queue has room; its results (zero to four per
//  point) leave one per cycle from the output register unless the output stalls, so
//  the back end sets the rate. An accepted point's job is written into the queue, and
//  the back end then loads its first result into the output register. Reset is
//  synchronous, active low, and clears the mode, the point count, the queue and the
//  output valid flag. A stalled output holds its point; the queue lets the input keep
//  flowing meanwhile, until it fills.
module curve_subdivision_step #(
    parameter int COORD_WIDTH = csub_pkg::DEF_COORD_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    csub_point_if.sink   i_pt,
    csub_point_if.source o_pt
);
    localparam int JOBW = csub_pkg::NTERM * (COORD_WIDTH + csub_pkg::GUARD_W) * 2
                          + $bits(csub_pkg::t_job_ctrl);

    logic            w_push, w_pop, w_full, w_empty;
    logic [JOBW-1:0] w_job_in, w_job_out;

    csub_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (i_pt),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    csub_fifo #(
        .DW    (JOBW),
        .DEPTH (csub_pkg::QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    csub_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_pt      (o_pt)
    );
endmodule

// ===== hw/rtl/csub_front.sv =====
// Front end: accepts control points, keeps history and classifies each point into a job.
module csub_front #(
    parameter int COORD_WIDTH = csub_pkg::DEF_COORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    csub_point_if.sink       i_pt,
    input  logic             i_q_full,
    output logic             o_push,
    output logic [csub_pkg::NTERM*(COORD_WIDTH+csub_pkg::GUARD_W)*2
                  + $bits(csub_pkg::t_job_ctrl)-1:0] o_job
);
    localparam int SW = COORD_WIDTH + csub_pkg::GUARD_W;

    logic                          r_mode;
    logic [1:0]                    r_seen;
    logic signed [COORD_WIDTH-1:0] r_hx [3];
    logic signed [COORD_WIDTH-1:0] r_hy [3];

    logic                             w_accept;
    logic                             w_has_res;
    csub_pkg::t_job_ctrl              w_ctrl;
    logic [csub_pkg::NTERM-1:0][SW-1:0] w_tx;
    logic [csub_pkg::NTERM-1:0][SW-1:0] w_ty;
    logic signed [SW-1:0] w_px, w_py;
    logic signed [SW-1:0] w_h0x, w_h0y, w_h1x, w_h1y, w_h2x, w_h2y;

    assign i_pt.ready = !i_q_full;
    assign w_accept   = i_pt.valid && i_pt.ready;

    assign w_px  = {{csub_pkg::GUARD_W{i_pt.x[COORD_WIDTH-1]}}, i_pt.x};
    assign w_py  = {{csub_pkg::GUARD_W{i_pt.y[COORD_WIDTH-1]}}, i_pt.y};
    assign w_h0x = {{csub_pkg::GUARD_W{r_hx[0][COORD_WIDTH-1]}}, r_hx[0]};
    assign w_h0y = {{csub_pkg::GUARD_W{r_hy[0][COORD_WIDTH-1]}}, r_hy[0]};
    assign w_h1x = {{csub_pkg::GUARD_W{r_hx[1][COORD_WIDTH-1]}}, r_hx[1]};
    assign w_h1y = {{csub_pkg::GUARD_W{r_hy[1][COORD_WIDTH-1]}}, r_hy[1]};
    assign w_h2x = {{csub_pkg::GUARD_W{r_hx[2][COORD_WIDTH-1]}}, r_hx[2]};
    assign w_h2y = {{csub_pkg::GUARD_W{r_hy[2][COORD_WIDTH-1]}}, r_hy[2]};

    always_comb begin
        w_tx[csub_pkg::T_A]  = (r_seen == 2'd2) ? (w_h1x <<< 1) - w_h0x : w_h2x;
        w_ty[csub_pkg::T_A]  = (r_seen == 2'd2) ? (w_h1y <<< 1) - w_h0y : w_h2y;
        w_tx[csub_pkg::T_H1] = w_h1x;
        w_ty[csub_pkg::T_H1] = w_h1y;
        w_tx[csub_pkg::T_H0] = w_h0x;
        w_ty[csub_pkg::T_H0] = w_h0y;
        w_tx[csub_pkg::T_P]  = w_px;
        w_ty[csub_pkg::T_P]  = w_py;
        w_tx[csub_pkg::T_G]  = (w_px <<< 1) - w_h0x;
        w_ty[csub_pkg::T_G]  = (w_py <<< 1) - w_h0y;
    end

    always_comb begin
        for (int k = 0; k < csub_pkg::MAX_RES; k++) begin
            w_ctrl.kinds[k] = csub_pkg::K_PT;
        end
        w_ctrl.last_idx = '0;
        w_ctrl.last     = i_pt.last;
        w_has_res       = 1'b1;
        case (r_seen)
            2'd0: begin
                w_ctrl.kinds[0] = csub_pkg::K_PT;
            end
            2'd1: begin
                if (!r_mode) begin
                    w_ctrl.kinds[0] = i_pt.last ? csub_pkg::K_PT : csub_pkg::K_MID;
                end else if (i_pt.last) begin
                    w_ctrl.kinds[0] = csub_pkg::K_MID;
                    w_ctrl.kinds[1] = csub_pkg::K_PT;
                    w_ctrl.last_idx = csub_pkg::RES_IDX_W'(1);
                end else begin
                    w_has_res = 1'b0;
                end
            end
            default: begin
                if (!r_mode) begin
                    w_ctrl.kinds[0] = csub_pkg::K_VTX;
                    w_ctrl.kinds[1] = csub_pkg::K_MID;
                    w_ctrl.kinds[2] = csub_pkg::K_PT;
                    w_ctrl.last_idx = csub_pkg::RES_IDX_W'(i_pt.last ? 2 : 1);
                end else begin
                    w_ctrl.kinds[0] = csub_pkg::K_FR1;
                    w_ctrl.kinds[1] = csub_pkg::K_HIST;
                    w_ctrl.kinds[2] = csub_pkg::K_FR2;
                    w_ctrl.kinds[3] = csub_pkg::K_PT;
                    w_ctrl.last_idx = csub_pkg::RES_IDX_W'(i_pt.last ? 3 : 1);
                end
            end
        endcase
    end

    assign o_push = w_accept && w_has_res;
    assign o_job  = {w_ctrl, w_tx, w_ty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_seen <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (i_pt.last) begin
                    r_seen <= 2'd0;
                end else if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_pt.last) begin
            r_hx[2] <= r_hx[1];
            r_hy[2] <= r_hy[1];
            r_hx[1] <= r_hx[0];
            r_hy[1] <= r_hy[0];
            r_hx[0] <= i_pt.x;
            r_hy[0] <= i_pt.y;
        end
    end
endmodule

// ===== hw/rtl/csub_fifo.sv =====
// Short job queue between the front and back ends.
module csub_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = csub_pkg::QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== hw/rtl/csub_back.sv =====
// Back end: evaluates each job's points into an output register, one per unstalled cycle.
`include "curve_subdivision_step_assert.svh"
module csub_back #(
    parameter int COORD_WIDTH = csub_pkg::DEF_COORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  logic [csub_pkg::NTERM*(COORD_WIDTH+csub_pkg::GUARD_W)*2
                  + $bits(csub_pkg::t_job_ctrl)-1:0] i_job,
    output logic             o_pop,
    csub_point_if.source     o_pt
);
    localparam int SW = COORD_WIDTH + csub_pkg::GUARD_W;
    localparam int EW = SW + 4;
    localparam int TW = csub_pkg::NTERM * SW;
    localparam int CTW = $bits(csub_pkg::t_job_ctrl);

    csub_pkg::t_job_ctrl                w_ctrl;
    logic [csub_pkg::NTERM-1:0][SW-1:0] w_tx, w_ty;
    csub_pkg::t_kind                    w_kind;
    logic                               w_step;
    logic                               w_end;

    logic [csub_pkg::RES_IDX_W-1:0] r_idx;
    logic                           r_ov;
    logic signed [COORD_WIDTH-1:0]  r_x, r_y;
    logic                           r_last;

    function automatic logic signed [COORD_WIDTH-1:0] calc(
        input csub_pkg::t_kind k,
        input logic [csub_pkg::NTERM-1:0][SW-1:0] t
    );
        logic signed [EW-1:0] a, b, c, d, g, v;
        logic signed [COORD_WIDTH-1:0] res;
        a = {{(EW-SW){t[csub_pkg::T_A][SW-1]}},  t[csub_pkg::T_A]};
        b = {{(EW-SW){t[csub_pkg::T_H1][SW-1]}}, t[csub_pkg::T_H1]};
        c = {{(EW-SW){t[csub_pkg::T_H0][SW-1]}}, t[csub_pkg::T_H0]};
        d = {{(EW-SW){t[csub_pkg::T_P][SW-1]}},  t[csub_pkg::T_P]};
        g = {{(EW-SW){t[csub_pkg::T_G][SW-1]}},  t[csub_pkg::T_G]};
        case (k)
            csub_pkg::K_MID:  v = (c + d) >>> 1;
            csub_pkg::K_VTX:  v = (b + (c <<< 2) + (c <<< 1) + d) >>> 3;
            csub_pkg::K_FR1:  v = ((b <<< 3) + b + (c <<< 3) + c - a - d) >>> 4;
            csub_pkg::K_FR2:  v = ((c <<< 3) + c + (d <<< 3) + d - b - g) >>> 4;
            csub_pkg::K_HIST: v = c;
            default:          v = d;
        endcase
        if (v[EW-1:COORD_WIDTH-1] == {(EW-COORD_WIDTH+1){v[EW-1]}}) begin
            res = v[COORD_WIDTH-1:0];
        end else if (v[EW-1]) begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_ctrl = i_job[2*TW +: CTW];
    assign w_tx   = i_job[TW +: TW];
    assign w_ty   = i_job[0 +: TW];
    assign w_kind = w_ctrl.kinds[r_idx];

    assign w_step = !i_q_empty && (!r_ov || o_pt.ready);
    assign w_end  = (r_idx == w_ctrl.last_idx);
    assign o_pop  = w_step && w_end;

    assign o_pt.valid = r_ov;
    assign o_pt.x     = r_x;
    assign o_pt.y     = r_y;
    assign o_pt.last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_step) begin
                r_ov  <= 1'b1;
                r_idx <= w_end ? '0 : r_idx + 1'b1;
            end else if (o_pt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_x    <= calc(w_kind, w_tx);
            r_y    <= calc(w_kind, w_ty);
            r_last <= w_ctrl.last && w_end;
        end
    end

    `CSUB_ASSERT(a_idx_in_job, i_clk, i_rst_n, !i_q_empty |-> (r_idx <= w_ctrl.last_idx), "result index past job end")
    `CSUB_ASSERT(a_job_held, i_clk, i_rst_n, (r_idx != '0) |-> !i_q_empty, "job left queue before its last result")
    `CSUB_ASSERT(a_last_flag, i_clk, i_rst_n, (w_step && !(w_end && w_ctrl.last)) |=> !r_last, "last flag on an inner result")
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for one curve subdivision level in both schemes.
module testbench;

    localparam int CW = csub_pkg::DEF_COORD_WIDTH;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam bit MODE_BSPLINE    = 1'b0;
    localparam bit MODE_FOUR_POINT = 1'b1;
    localparam int RANDOM_POINTS   = 240;
    localparam int CALM_TAIL       = 50;
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef logic signed [CW-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_refined_pt;

    class refinement_board;
        bit          mode;
        longint      hx[3];
        longint      hy[3];
        int unsigned seen;
        t_refined_pt expected_points[$];
        int          mismatches;

        function t_coord clamp(longint v);
            if (v > longint'(C_MAX)) return C_MAX;
            if (v < longint'(C_MIN)) return C_MIN;
            return t_coord'(v);
        endfunction

        function void push(longint x, longint y, logic last);
            t_refined_pt p;
            p.x = clamp(x);
            p.y = clamp(y);
            p.last = last;
            expected_points.insert(expected_points.size(), p);
        endfunction

        function longint four_rule(longint a, longint b, longint c, longint d);
            return (9 * (b + c) - a - d) >>> 4;
        endfunction

        function void note_control_point(t_coord x, t_coord y, logic last);
            longint px, py, ax, ay;
            px = x;
            py = y;
            if (seen == 0) begin
                push(px, py, last);
            end else if (seen == 1) begin
                if (mode == MODE_BSPLINE) begin
                    if (last) push(px, py, 1'b1);
                    else push((hx[0] + px) >>> 1, (hy[0] + py) >>> 1, 1'b0);
                end else if (last) begin
                    push((hx[0] + px) >>> 1, (hy[0] + py) >>> 1, 1'b0);
                    push(px, py, 1'b1);
                end
            end else if (mode == MODE_BSPLINE) begin
                push((hx[1] + 6 * hx[0] + px) >>> 3,
                     (hy[1] + 6 * hy[0] + py) >>> 3, 1'b0);
                push((hx[0] + px) >>> 1, (hy[0] + py) >>> 1, 1'b0);
                if (last) push(px, py, 1'b1);
            end else begin
                // use the mirrored leading ghost on the third point
                ax = (seen == 2) ? 2 * hx[1] - hx[0] : hx[2];
                ay = (seen == 2) ? 2 * hy[1] - hy[0] : hy[2];
                push(four_rule(ax, hx[1], hx[0], px),
                     four_rule(ay, hy[1], hy[0], py), 1'b0);
                push(hx[0], hy[0], 1'b0);
                if (last) begin
                    push(four_rule(hx[1], hx[0], px, 2 * px - hx[0]),
                         four_rule(hy[1], hy[0], py, 2 * py - hy[0]), 1'b0);
                    push(px, py, 1'b1);
                end
            end
            if (last) begin
                seen = 0;
            end else begin
                hx[2] = hx[1]; hy[2] = hy[1];
                hx[1] = hx[0]; hy[1] = hy[0];
                hx[0] = px;    hy[0] = py;
                if (seen < 3) seen++;
            end
        endfunction

        function void check_refined_point(t_coord x, t_coord y, logic last);
            t_refined_pt want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected refined point x=%0d y=%0d last=%0b", x, y, last);
                return;
            end
            want = expected_points.pop_front();
            if (want.x !== x || want.y !== y || want.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected x=%0d y=%0d last=%0b, %s",
                             want.x, want.y, want.last,
                             $sformatf("got x=%0d y=%0d last=%0b", x, y, last));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    bit   idle_on = 1'b1;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    refinement_board board;

    csub_point_if #(.COORD_WIDTH(CW)) pt_in ();
    csub_point_if #(.COORD_WIDTH(CW)) pt_out ();

    curve_subdivision_step #(.COORD_WIDTH(CW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (pt_in),
        .o_pt        (pt_out)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            pt_out.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            pt_out.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            pt_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pt_out.valid && pt_out.ready)
            board.check_refined_point(pt_out.x, pt_out.y, pt_out.last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3: return '1;
            4, 5, 6: return t_coord'($urandom);
            default: return t_coord'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic send_control_point(t_coord x, t_coord y, logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pt_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.x     <= x;
        pt_in.y     <= y;
        pt_in.last  <= last;
        do @(posedge i_clk); while (!pt_in.ready);
        board.note_control_point(x, y, last);
    endtask

    task automatic drain_results();
        pt_in.valid <= 1'b0;
        while (board.expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scheme_mode(bit m);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.mode = m;
    endtask

    initial begin
        int sent;
        int len;
        int switch_at;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        pt_in.valid  = 1'b0;
        pt_in.x      = '0;
        pt_in.y      = '0;
        pt_in.last   = 1'b0;
        pt_out.ready = 1'b0;
        board = new;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_scheme_mode(MODE_BSPLINE);
        send_control_point(C_MAX, C_MIN, 1'b1);
        send_control_point(C_MIN, C_MIN, 1'b0);
        send_control_point(C_MAX, C_MAX, 1'b1);
        send_control_point(C_MAX, C_MIN, 1'b0);
        send_control_point(C_MIN, C_MAX, 1'b0);
        send_control_point(C_MAX, C_MIN, 1'b0);
        send_control_point('0, '1, 1'b1);

        write_scheme_mode(MODE_FOUR_POINT);
        send_control_point(C_MIN, C_MAX, 1'b1);
        send_control_point(C_MAX, C_MIN, 1'b0);
        send_control_point(C_MIN, C_MAX, 1'b1);
        send_control_point(C_MIN, C_MIN, 1'b0);
        send_control_point(C_MAX, C_MAX, 1'b0);
        send_control_point(C_MAX, C_MAX, 1'b0);
        send_control_point(C_MIN, C_MIN, 1'b0);
        send_control_point(C_MIN, C_MAX, 1'b1);

        // switch schemes partway through one curve
        send_control_point(t_coord'(256), t_coord'(-256), 1'b0);
        send_control_point(t_coord'(-3), t_coord'(7), 1'b0);
        send_control_point(t_coord'(100), t_coord'(-100), 1'b0);
        write_scheme_mode(MODE_BSPLINE);
        send_control_point(C_MAX, t_coord'(1), 1'b0);
        send_control_point(C_MIN, t_coord'(-1), 1'b1);

        while (sent < RANDOM_POINTS) begin
            if (sent >= RANDOM_POINTS - CALM_TAIL) idle_on = 1'b0;
            if ($urandom_range(0, 4) == 0) write_scheme_mode(bit'($urandom_range(0, 1)));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                              : $urandom_range(1, 6);
            switch_at = (len > 1 && $urandom_range(0, 7) == 0)
                        ? $urandom_range(1, len - 1) : 0;
            for (int k = 0; k < len; k++) begin
                if (k != 0 && k == switch_at) write_scheme_mode(!board.mode);
                send_control_point(rand_coord(), rand_coord(), k == len - 1);
                sent++;
            end
        end

        drain_results();
        if (board.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
